FILE: rtl/hgrc_pkg.sv
// Shared types, widths and constants for the HSV row gradient color block.
// Used by every module under rtl/; depends on nothing.
package hgrc_pkg;

    localparam int ROW_W      = 12;
    localparam int HUE_W      = 17;
    localparam int CH_W       = 8;
    localparam int HNUM_W     = HUE_W + ROW_W;
    localparam int CNUM_W     = CH_W + ROW_W;
    localparam int DIV_STAGES = HUE_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = HUE_W;
    localparam int S_TDATA_W  = ((ROW_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 3 * CH_W;

    localparam int HUE_SECTOR_I = 15360;
    localparam int SEC_MAX      = ((1 << HUE_W) - 1) / HUE_SECTOR_I;
    localparam int SEC_IDX_W    = $clog2(SEC_MAX + 1);
    localparam int FR_W         = $clog2(HUE_SECTOR_I + 1);
    localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(HUE_SECTOR_I);
    localparam logic [CH_W-1:0]  FULL       = 8'd255;

    localparam int PROD_W   = FR_W + CH_W;
    localparam int PV_W     = 2 * CH_W;
    localparam int PVS_W    = PV_W + 1;
    localparam int XQ_W     = 30;
    localparam int DEN_POW2 = 10;
    localparam logic [PROD_W-1:0] DEN = PROD_W'(255 * HUE_SECTOR_I);

    // floor(x / 3825) for x < 2^20 as (x * RECIP_M) >> RECIP_SHIFT
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP_M = 21'd1122868;
    localparam int MQ_W = XQ_W - DEN_POW2 + RECIP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_HUE    = 3'd0,
        CFG_TOP_SAT    = 3'd1,
        CFG_TOP_VAL    = 3'd2,
        CFG_BOTTOM_HUE = 3'd3,
        CFG_BOTTOM_SAT = 3'd4,
        CFG_BOTTOM_VAL = 3'd5,
        CFG_ROWS       = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0] top_hue;
        logic [CH_W-1:0]  top_sat;
        logic [CH_W-1:0]  top_val;
        logic [HUE_W-1:0] bottom_hue;
        logic [CH_W-1:0]  bottom_sat;
        logic [CH_W-1:0]  bottom_val;
        logic [ROW_W-1:0] rows_in_frame;
    } cfg_t;

    // interpolation numerators; low bits turn into quotient bits in the divider
    typedef struct packed {
        logic [HNUM_W-1:0] hue;
        logic [CNUM_W-1:0] sat;
        logic [CNUM_W-1:0] val;
        logic              bypass;
    } num_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
        logic             bypass;
    } hsv_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    function automatic logic [HUE_W-1:0] sector_base(input logic [SEC_IDX_W-1:0] k);
        sector_base = HUE_W'(k) * HUE_SECTOR;
    endfunction

    function automatic sector_t sector_of(input logic [SEC_IDX_W-1:0] k);
        if (k >= SEC_IDX_W'(6)) begin
            sector_of = sector_t'(3'(k - SEC_IDX_W'(6)));
        end else begin
            sector_of = sector_t'(3'(k));
        end
    endfunction

endpackage

FILE: rtl/hgrc_cfg_regs.sv
// Configuration register file: gradient endpoints and row count.
// Depends on hgrc_pkg.
module hgrc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hgrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hgrc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hgrc_pkg::cfg_t                   cfg
);

    hgrc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.top_hue       <= '0;
            cfg_reg.top_sat       <= 8'd3;
            cfg_reg.top_val       <= 8'd230;
            cfg_reg.bottom_hue    <= '0;
            cfg_reg.bottom_sat    <= 8'd3;
            cfg_reg.bottom_val    <= 8'd26;
            cfg_reg.rows_in_frame <= 12'd600;
        end else if (cfg_valid && cfg_ready) begin
            case (hgrc_pkg::cfg_idx_t'(cfg_index))
                hgrc_pkg::CFG_TOP_HUE: begin
                    cfg_reg.top_hue <= cfg_data;
                end
                hgrc_pkg::CFG_TOP_SAT: begin
                    cfg_reg.top_sat <= cfg_data[hgrc_pkg::CH_W-1:0];
                end
                hgrc_pkg::CFG_TOP_VAL: begin
                    cfg_reg.top_val <= cfg_data[hgrc_pkg::CH_W-1:0];
                end
                hgrc_pkg::CFG_BOTTOM_HUE: begin
                    cfg_reg.bottom_hue <= cfg_data;
                end
                hgrc_pkg::CFG_BOTTOM_SAT: begin
                    cfg_reg.bottom_sat <= cfg_data[hgrc_pkg::CH_W-1:0];
                end
                hgrc_pkg::CFG_BOTTOM_VAL: begin
                    cfg_reg.bottom_val <= cfg_data[hgrc_pkg::CH_W-1:0];
                end
                hgrc_pkg::CFG_ROWS: begin
                    cfg_reg.rows_in_frame <= cfg_data[hgrc_pkg::ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/hgrc_lerp_mul.sv
// Front end: row clamp, endpoint products and interpolation numerators.
// Three register stages; depends on hgrc_pkg.
module hgrc_lerp_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hgrc_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hgrc_pkg::ROW_W-1:0]    in_row,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hgrc_pkg::num_t                out_num
);

    localparam int RW = hgrc_pkg::ROW_W;
    localparam int HW = hgrc_pkg::HNUM_W;
    localparam int CW = hgrc_pkg::CNUM_W;

    typedef struct packed {
        logic [RW-1:0] y;
        logic [RW-1:0] d;
        logic          bypass;
    } clamp_t;

    typedef struct packed {
        logic [HW-1:0] hue_a;
        logic [HW-1:0] hue_b;
        logic [CW-1:0] sat_a;
        logic [CW-1:0] sat_b;
        logic [CW-1:0] val_a;
        logic [CW-1:0] val_b;
        logic          bypass;
    } prod_t;

    clamp_t         a_reg, a_next;
    prod_t          b_reg, b_next;
    hgrc_pkg::num_t c_reg, c_next;
    logic           a_vld_reg, b_vld_reg, c_vld_reg;
    logic           a_rdy, b_rdy, c_rdy;

    assign c_rdy    = !c_vld_reg || out_ready;
    assign b_rdy    = !b_vld_reg || c_rdy;
    assign a_rdy    = !a_vld_reg || b_rdy;
    assign in_ready = a_rdy;

    // rows at or past the count (and every row when the count is zero) take the bottom color
    always_comb begin
        a_next.y      = in_row;
        a_next.d      = cfg.rows_in_frame - in_row;
        a_next.bypass = (in_row >= cfg.rows_in_frame);
    end

    always_comb begin
        b_next.hue_a  = HW'(cfg.top_hue) * HW'(a_reg.d);
        b_next.hue_b  = HW'(cfg.bottom_hue) * HW'(a_reg.y);
        b_next.sat_a  = CW'(cfg.top_sat) * CW'(a_reg.d);
        b_next.sat_b  = CW'(cfg.bottom_sat) * CW'(a_reg.y);
        b_next.val_a  = CW'(cfg.top_val) * CW'(a_reg.d);
        b_next.val_b  = CW'(cfg.bottom_val) * CW'(a_reg.y);
        b_next.bypass = a_reg.bypass;
    end

    always_comb begin
        c_next.hue    = b_reg.hue_a + b_reg.hue_b;
        c_next.sat    = b_reg.sat_a + b_reg.sat_b;
        c_next.val    = b_reg.val_a + b_reg.val_b;
        c_next.bypass = b_reg.bypass;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (a_rdy) begin
                a_vld_reg <= in_valid;
            end
            if (b_rdy) begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_rdy) begin
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && in_valid) begin
            a_reg <= a_next;
        end
        if (b_rdy && a_vld_reg) begin
            b_reg <= b_next;
        end
        if (c_rdy && b_vld_reg) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_num   = c_reg;

endmodule

FILE: rtl/hgrc_div_pipe.sv
// Pipelined restoring divider: numerators over rows_in_frame, one quotient bit per stage.
// Hue lane runs all stages, saturation and value lanes finish early; depends on hgrc_pkg.
module hgrc_div_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hgrc_pkg::ROW_W-1:0]    rows,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hgrc_pkg::num_t                in_num,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hgrc_pkg::hsv_t                out_hsv
);

    localparam int RW = hgrc_pkg::ROW_W;
    localparam int QH = hgrc_pkg::HUE_W;
    localparam int QC = hgrc_pkg::CH_W;
    localparam int HW = hgrc_pkg::HNUM_W;
    localparam int CW = hgrc_pkg::CNUM_W;
    localparam int N  = hgrc_pkg::DIV_STAGES;

    function automatic hgrc_pkg::num_t div_step(input hgrc_pkg::num_t cur,
                                                input logic [RW-1:0]   r,
                                                input logic            do_ch);
        hgrc_pkg::num_t nxt;
        logic [RW:0]    trial;
        logic [RW:0]    rem;
        logic           ge;
        nxt = cur;
        trial = {cur.hue[HW-1:QH], cur.hue[QH-1]};
        ge = (trial >= {1'b0, r});
        rem = ge ? (trial - {1'b0, r}) : trial;
        nxt.hue = {rem[RW-1:0], cur.hue[QH-2:0], ge};
        if (do_ch) begin
            trial = {cur.sat[CW-1:QC], cur.sat[QC-1]};
            ge = (trial >= {1'b0, r});
            rem = ge ? (trial - {1'b0, r}) : trial;
            nxt.sat = {rem[RW-1:0], cur.sat[QC-2:0], ge};
            trial = {cur.val[CW-1:QC], cur.val[QC-1]};
            ge = (trial >= {1'b0, r});
            rem = ge ? (trial - {1'b0, r}) : trial;
            nxt.val = {rem[RW-1:0], cur.val[QC-2:0], ge};
        end
        div_step = nxt;
    endfunction

    hgrc_pkg::num_t st_reg  [N];
    hgrc_pkg::num_t st_in   [N];
    hgrc_pkg::num_t st_next [N];
    logic [N-1:0]   vld_reg;
    logic [N-1:0]   vin;
    logic [N:0]     rdy;

    assign rdy[N] = out_ready;

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == 0) begin : g_head
            assign st_in[k] = in_num;
            assign vin[k]   = in_valid;
        end else begin : g_body
            assign st_in[k] = st_reg[k-1];
            assign vin[k]   = vld_reg[k-1];
        end
        assign rdy[k]     = !vld_reg[k] || rdy[k+1];
        assign st_next[k] = div_step(st_in[k], rows, (k < QC) ? 1'b1 : 1'b0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < N; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vin[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (rdy[i] && vin[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign in_ready       = rdy[0];
    assign out_valid      = vld_reg[N-1];
    assign out_hsv.hue    = st_reg[N-1].hue[QH-1:0];
    assign out_hsv.sat    = st_reg[N-1].sat[QC-1:0];
    assign out_hsv.val    = st_reg[N-1].val[QC-1:0];
    assign out_hsv.bypass = st_reg[N-1].bypass;

endmodule

FILE: rtl/hgrc_hsv2rgb.sv
// Six-sector HSV to RGB conversion with p, q and t channels, five register stages.
// The last stage is the output register; depends on hgrc_pkg.
module hgrc_hsv2rgb (
    input  logic              aclk,
    input  logic              aresetn,
    input  hgrc_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  hgrc_pkg::hsv_t    in_hsv,
    output logic              out_valid,
    input  logic              out_ready,
    output hgrc_pkg::rgb_t    out_rgb
);

    localparam int HW  = hgrc_pkg::HUE_W;
    localparam int CHW = hgrc_pkg::CH_W;
    localparam int FW  = hgrc_pkg::FR_W;
    localparam int PW  = hgrc_pkg::PROD_W;
    localparam int VW  = hgrc_pkg::PV_W;
    localparam int VSW = hgrc_pkg::PVS_W;
    localparam int XW  = hgrc_pkg::XQ_W;
    localparam int MW  = hgrc_pkg::MQ_W;
    localparam int KW  = hgrc_pkg::SEC_IDX_W;
    localparam int SH  = hgrc_pkg::RECIP_SHIFT;

    typedef struct packed {
        hgrc_pkg::sector_t sector;
        logic [FW-1:0]     fr;
        logic [CHW-1:0]    sat;
        logic [CHW-1:0]    val;
    } sect_t;

    typedef struct packed {
        hgrc_pkg::sector_t sector;
        logic [PW-1:0]     fq;
        logic [PW-1:0]     ft;
        logic [VW-1:0]     pv;
        logic [CHW-1:0]    val;
    } scale_t;

    typedef struct packed {
        hgrc_pkg::sector_t sector;
        logic [XW-1:0]     xq;
        logic [XW-1:0]     xt;
        logic [CHW-1:0]    cp;
        logic [CHW-1:0]    val;
    } chan_t;

    typedef struct packed {
        hgrc_pkg::sector_t sector;
        logic [MW-1:0]     mq;
        logic [MW-1:0]     mt;
        logic [CHW-1:0]    cp;
        logic [CHW-1:0]    val;
    } recip_t;

    sect_t          s1_reg, s1_next;
    scale_t         s2_reg, s2_next;
    chan_t          s3_reg, s3_next;
    recip_t         s4_reg, s4_next;
    hgrc_pkg::rgb_t s5_reg, s5_next;
    logic           s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic           s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

    logic [HW-1:0]  hue_sel;
    logic [KW-1:0]  k;
    logic [VSW-1:0] pv_sum;
    logic [CHW-1:0] cq, ct;

    assign s5_rdy   = !s5_vld_reg || out_ready;
    assign s4_rdy   = !s4_vld_reg || s5_rdy;
    assign s3_rdy   = !s3_vld_reg || s4_rdy;
    assign s2_rdy   = !s2_vld_reg || s3_rdy;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign in_ready = s1_rdy;

    // sector index by parallel compares against multiples of 60 degrees
    always_comb begin
        hue_sel = in_hsv.bypass ? cfg.bottom_hue : in_hsv.hue;
        k = '0;
        for (int j = 1; j <= hgrc_pkg::SEC_MAX; j++) begin
            if (hue_sel >= hgrc_pkg::sector_base(KW'(j))) begin
                k = KW'(j);
            end
        end
        s1_next.sector = hgrc_pkg::sector_of(k);
        s1_next.fr     = FW'(hue_sel - hgrc_pkg::sector_base(k));
        s1_next.sat    = in_hsv.bypass ? cfg.bottom_sat : in_hsv.sat;
        s1_next.val    = in_hsv.bypass ? cfg.bottom_val : in_hsv.val;
    end

    always_comb begin
        s2_next.sector = s1_reg.sector;
        s2_next.fq     = PW'(s1_reg.fr) * PW'(s1_reg.sat);
        s2_next.ft     = PW'(FW'(hgrc_pkg::HUE_SECTOR) - s1_reg.fr) * PW'(s1_reg.sat);
        s2_next.pv     = VW'(s1_reg.val) * VW'(hgrc_pkg::FULL - s1_reg.sat);
        s2_next.val    = s1_reg.val;
    end

    // x / 255 = (x + (x >> 8) + 1) >> 8 for x up to 255 * 255
    always_comb begin
        pv_sum         = VSW'(s2_reg.pv) + VSW'(s2_reg.pv >> CHW) + VSW'(1);
        s3_next.sector = s2_reg.sector;
        s3_next.xq     = XW'(s2_reg.val) * XW'(hgrc_pkg::DEN - s2_reg.fq);
        s3_next.xt     = XW'(s2_reg.val) * XW'(hgrc_pkg::DEN - s2_reg.ft);
        s3_next.cp     = pv_sum[VW-1:CHW];
        s3_next.val    = s2_reg.val;
    end

    always_comb begin
        s4_next.sector = s3_reg.sector;
        s4_next.mq     = MW'(s3_reg.xq[XW-1:hgrc_pkg::DEN_POW2]) * MW'(hgrc_pkg::RECIP_M);
        s4_next.mt     = MW'(s3_reg.xt[XW-1:hgrc_pkg::DEN_POW2]) * MW'(hgrc_pkg::RECIP_M);
        s4_next.cp     = s3_reg.cp;
        s4_next.val    = s3_reg.val;
    end

    always_comb begin
        cq = s4_reg.mq[SH+CHW-1:SH];
        ct = s4_reg.mt[SH+CHW-1:SH];
        case (s4_reg.sector)
            hgrc_pkg::SEC_RED: begin
                s5_next = '{blue: s4_reg.cp, green: ct, red: s4_reg.val};
            end
            hgrc_pkg::SEC_YELLOW: begin
                s5_next = '{blue: s4_reg.cp, green: s4_reg.val, red: cq};
            end
            hgrc_pkg::SEC_GREEN: begin
                s5_next = '{blue: ct, green: s4_reg.val, red: s4_reg.cp};
            end
            hgrc_pkg::SEC_CYAN: begin
                s5_next = '{blue: s4_reg.val, green: cq, red: s4_reg.cp};
            end
            hgrc_pkg::SEC_BLUE: begin
                s5_next = '{blue: s4_reg.val, green: s4_reg.cp, red: ct};
            end
            hgrc_pkg::SEC_MAGENTA: begin
                s5_next = '{blue: cq, green: s4_reg.cp, red: s4_reg.val};
            end
            default: begin
                s5_next = '{blue: cq, green: s4_reg.cp, red: s4_reg.val};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end else begin
            if (s1_rdy) begin
                s1_vld_reg <= in_valid;
            end
            if (s2_rdy) begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s3_rdy) begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (s4_rdy) begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (s5_rdy) begin
                s5_vld_reg <= s4_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy && in_valid) begin
            s1_reg <= s1_next;
        end
        if (s2_rdy && s1_vld_reg) begin
            s2_reg <= s2_next;
        end
        if (s3_rdy && s2_vld_reg) begin
            s3_reg <= s3_next;
        end
        if (s4_rdy && s3_vld_reg) begin
            s4_reg <= s4_next;
        end
        if (s5_rdy && s4_vld_reg) begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = s5_vld_reg;
    assign out_rgb   = s5_reg;

endmodule

FILE: rtl/hsv_gradient_row_color.sv
// Top level of the HSV row gradient color block.
// Instantiates hgrc_cfg_regs, hgrc_lerp_mul, hgrc_div_pipe and hgrc_hsv2rgb; uses hgrc_pkg.
//
// Give it a row index and it returns the RGB color of a vertical gradient at that row: hue,
// saturation and value are interpolated between the top and bottom endpoints over
// rows_in_frame rows (rows at or past that count get the bottom color), then converted with
// the six-sector HSV to RGB formula, channels truncated to 8 bits. One row word is taken
// every clock while the output side is not stalled, and results come out in order through
// 3 stages of row clamp, products and sums, 17 divider stages that each resolve one quotient
// bit of the division by rows_in_frame, and 5 stages of color conversion. Every stage holds
// its word independently, so a stall on the output only stops input once all stages are
// full. Registers reset to a light-to-dark near-gray fade over 600 rows and are written
// through the cfg port (always ready; unknown indexes are ignored); the user must write
// them only while no row is in flight, which the block itself does not enforce.
module hsv_gradient_row_color (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hgrc_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] row
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hgrc_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hgrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hgrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    hgrc_pkg::cfg_t cfg;
    hgrc_pkg::num_t num;
    hgrc_pkg::hsv_t hsv;
    hgrc_pkg::rgb_t rgb;
    logic           num_valid, num_ready;
    logic           hsv_valid, hsv_ready;

    hgrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hgrc_lerp_mul u_lerp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_row    (s_tdata[hgrc_pkg::ROW_W-1:0]),
        .out_valid (num_valid),
        .out_ready (num_ready),
        .out_num   (num)
    );

    hgrc_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rows      (cfg.rows_in_frame),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .in_num    (num),
        .out_valid (hsv_valid),
        .out_ready (hsv_ready),
        .out_hsv   (hsv)
    );

    hgrc_hsv2rgb u_rgb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (hsv_valid),
        .in_ready  (hsv_ready),
        .in_hsv    (hsv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rgb   (rgb)
    );

    assign m_tdata = rgb;

endmodule

FILE: rtl/hgrc_checker.sv
// Port-level checks for hsv_gradient_row_color, attached by the bind below.
// Depends on hgrc_pkg for port widths.
module hgrc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hgrc_pkg::M_TDATA_W-1:0]  m_tdata
);

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word present right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed or dropped");

    // the pipeline only pushes back when the output word is stuck
    a_backpressure_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the output side is free");

endmodule

bind hsv_gradient_row_color hgrc_checker u_hgrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
